// ===== rtl/core/bfp_pkg.sv =====
// ----------------------------------------------------------------------------
// bfp_pkg
// Shared types, codes and character constants for the bracket frame parser.
// ----------------------------------------------------------------------------
package bfp_pkg;

  localparam int unsigned UnitCharsDefault = 2;

  localparam int unsigned CharW  = 8;
  localparam int unsigned CountW = 7;
  localparam int unsigned StageW = 3;
  localparam int unsigned EventW = 2;

  // parser stage codes
  localparam logic [StageW-1:0] StWait = 3'd0;
  localparam logic [StageW-1:0] StCmd  = 3'd1;
  localparam logic [StageW-1:0] StLen  = 3'd2;
  localparam logic [StageW-1:0] StData = 3'd3;
  localparam logic [StageW-1:0] StEnd  = 3'd4;

  // event codes
  localparam logic [EventW-1:0] EvNone = 2'd0;
  localparam logic [EventW-1:0] EvData = 2'd1;
  localparam logic [EventW-1:0] EvDone = 2'd2;
  localparam logic [EventW-1:0] EvDrop = 2'd3;

  localparam logic [CharW-1:0] ChOpen  = 8'h5B; // '['
  localparam logic [CharW-1:0] ChClose = 8'h5D; // ']'
  localparam logic [CharW-1:0] ChUpA   = 8'h41; // 'A'
  localparam logic [CharW-1:0] ChUpZ   = 8'h5A; // 'Z'
  localparam logic [CharW-1:0] ChLoA   = 8'h61; // 'a'
  localparam logic [CharW-1:0] ChLoZ   = 8'h7A; // 'z'
  localparam logic [CharW-1:0] ChDig0  = 8'h30; // '0'
  localparam logic [CharW-1:0] ChDig1  = 8'h31; // '1'
  localparam logic [CharW-1:0] ChDig9  = 8'h39; // '9'

  typedef struct packed {
    logic [StageW-1:0] stage;
    logic [CountW-1:0] expected;
    logic [CountW-1:0] received;
    logic [CharW-1:0]  command;
  } parse_state_t;

  typedef struct packed {
    logic [EventW-1:0] event_res;
    logic [CharW-1:0]  data_byte;
    logic [CountW-1:0] data_index;
    logic [CharW-1:0]  command;
    logic [CountW-1:0] msg_length;
  } parse_result_t;

endpackage

// ===== rtl/core/bfp_step.sv =====
// ----------------------------------------------------------------------------
// bfp_step
// One parser step: classifies a character and computes next state and event.
// ----------------------------------------------------------------------------
module bfp_step import bfp_pkg::*; #(
  parameter int unsigned UnitChars = UnitCharsDefault
) (
  input  logic [CharW-1:0] char_i,
  input  parse_state_t     state_i,
  output parse_state_t     state_o,
  output parse_result_t    res_o
);

  logic              is_upper;
  logic              is_payload;
  logic              is_digit;
  logic [CountW-1:0] unit;
  logic [CountW-1:0] digit;
  logic [CountW-1:0] exp_len;
  logic [CountW-1:0] rcv_inc;

  assign is_upper   = (char_i >= ChUpA) && (char_i <= ChUpZ);
  assign is_digit   = (char_i >= ChDig0) && (char_i <= ChDig9);
  assign is_payload = is_upper || is_digit || ((char_i >= ChLoA) && (char_i <= ChLoZ));

  assign unit    = CountW'(UnitChars);
  assign digit   = CountW'(char_i - ChDig0);
  assign exp_len = CountW'(unit * digit);
  assign rcv_inc = CountW'(state_i.received + 1'b1);

  always_comb begin
    state_o          = state_i;
    res_o.event_res  = EvNone;
    res_o.data_byte  = '0;
    res_o.data_index = '0;
    res_o.msg_length = '0;

    case (state_i.stage)
      StCmd: begin
        if (is_upper) begin
          state_o.command  = char_i;
          state_o.received = '0;
          state_o.stage    = StLen;
        end else begin
          state_o.stage   = StWait;
          res_o.event_res = EvDrop;
        end
      end
      StLen: begin
        state_o.received = '0;
        if (char_i == ChDig0) begin
          state_o.expected = '0;
          state_o.stage    = StEnd;
        end else if ((char_i >= ChDig1) && (char_i <= ChDig9)) begin
          state_o.expected = exp_len;
          state_o.stage    = (exp_len == '0) ? StEnd : StData;
        end else if (char_i == ChOpen) begin
          state_o.stage   = StCmd;
          res_o.event_res = EvDrop;
        end else begin
          state_o.stage   = StWait;
          res_o.event_res = EvDrop;
        end
      end
      StData: begin
        if (is_payload) begin
          res_o.event_res  = EvData;
          res_o.data_byte  = char_i;
          res_o.data_index = state_i.received;
          state_o.received = rcv_inc;
          if (rcv_inc >= state_i.expected) begin
            state_o.stage = StEnd;
          end
        end else if (char_i == ChOpen) begin
          state_o.stage   = StCmd;
          res_o.event_res = EvDrop;
        end else begin
          state_o.stage   = StWait;
          res_o.event_res = EvDrop;
        end
      end
      StEnd: begin
        if (char_i == ChClose) begin
          res_o.event_res  = EvDone;
          res_o.msg_length = state_i.expected;
          state_o.stage    = StWait;
        end else if (char_i == ChOpen) begin
          state_o.stage   = StCmd;
          res_o.event_res = EvDrop;
        end else begin
          state_o.stage   = StWait;
          res_o.event_res = EvDrop;
        end
      end
      default: begin
        // wait stage; unused codes behave the same
        state_o.stage = StWait;
        if (char_i == ChOpen) begin
          state_o.received = '0;
          state_o.stage    = StCmd;
        end
      end
    endcase

    res_o.command = state_o.command;
  end

endmodule

// ===== rtl/core/bracket_frame_parser.sv =====
// ----------------------------------------------------------------------------
// bracket_frame_parser
// Character-serial recognizer for frames '[' CMD LEN DATA... ']'.
// ----------------------------------------------------------------------------
// Pipeline: the input register captures the character, then the step logic
//   writes the result register together with the state; out_valid_o rises
//   when the result register loads, which waits while the result slot is full.
// Throughput: 1 character per cycle while the consumer keeps up; the state
//   update loop through bfp_step sets this rate.
// Reset: asynchronous, active low; parser returns to the wait stage with
//   counts and command cleared, both pipeline registers empty.
module bracket_frame_parser import bfp_pkg::*; #(
  parameter int unsigned UnitChars = UnitCharsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,

  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CharW-1:0]  char_in_i,

  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [EventW-1:0] event_res_o,
  output logic [CharW-1:0]  data_byte_o,
  output logic [CountW-1:0] data_index_o,
  output logic [CharW-1:0]  command_o,
  output logic [CountW-1:0] msg_length_o
);

  // input register
  logic             in_vld_q, in_vld_d;
  logic [CharW-1:0] char_q;

  // parser state, updated only when a character moves into the result slot
  parse_state_t  state_q, state_d;
  parse_result_t step_res;

  // result register
  logic          out_vld_q, out_vld_d;
  parse_result_t res_q;

  logic advance;

  // A character advances when the result slot is empty or is being drained
  // this cycle. The input slot refills in the same cycle, so back-to-back
  // transfers run at full rate while the consumer keeps up.
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  assign in_vld_d  = (in_valid_i && in_ready_o) ? 1'b1 : (advance ? 1'b0 : in_vld_q);
  assign out_vld_d = advance ? 1'b1 : ((out_vld_q && out_ready_i) ? 1'b0 : out_vld_q);

  bfp_step #(
    .UnitChars (UnitChars)
  ) u_step (
    .char_i  (char_q),
    .state_i (state_q),
    .state_o (state_d),
    .res_o   (step_res)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '{stage: StWait, expected: '0, received: '0, command: '0};
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q <= char_in_i;
    end
    if (advance) begin
      res_q <= step_res;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign event_res_o  = res_q.event_res;
  assign data_byte_o  = res_q.data_byte;
  assign data_index_o = res_q.data_index;
  assign command_o    = res_q.command;
  assign msg_length_o = res_q.msg_length;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // stage never leaves the defined codes
  a_stage_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.stage <= StEnd)
    else $error("parser stage out of range");

  // a held data result matches the received count it produced
  a_data_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (res_q.event_res == EvData)) |->
      (state_q.received == CountW'(res_q.data_index + 1'b1)))
    else $error("data index does not match received count");

  // completion returns to wait and reports the expected length
  a_done_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (res_q.event_res == EvDone)) |->
      ((state_q.stage == StWait) && (res_q.msg_length == state_q.expected)))
    else $error("completion inconsistent with parser state");

  // reported command always tracks the live command letter
  a_cmd_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (res_q.command == state_q.command))
    else $error("command output out of step with state");

  // a stalled input slot keeps its character
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !advance) |=> (in_vld_q && $stable(char_q)))
    else $error("input slot lost a pending character");

endmodule

// ===== tb/bfp_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// bfp_tb_pkg
// Scoreboard for the bracket frame parser: a cycle-free parser model that
// turns each accepted character into the event it should cause, plus an
// in-order checker for the events the block returns.
// ----------------------------------------------------------------------------
package bfp_tb_pkg;

  import bfp_pkg::*;

  localparam int unsigned UNIT_CHARS  = UnitCharsDefault;
  localparam int          MAX_REPORTS = 100;

  class frame_scoreboard;

    parse_result_t pending_events[$];
    int            mismatches;

    logic [StageW-1:0] stage_q;
    logic [CountW-1:0] need_cnt;
    logic [CountW-1:0] got_cnt;
    logic [CharW-1:0]  cmd_q;

    function new();
      mismatches = 0;
      stage_q    = StWait;
      need_cnt   = '0;
      got_cnt    = '0;
      cmd_q      = '0;
    endfunction

    function bit is_upper(logic [CharW-1:0] c);
      return c >= ChUpA && c <= ChUpZ;
    endfunction

    function bit is_payload(logic [CharW-1:0] c);
      return is_upper(c) || (c >= ChLoA && c <= ChLoZ) || (c >= ChDig0 && c <= ChDig9);
    endfunction

    // advance the parser by one character, return the event it raises
    function parse_result_t parse_char(logic [CharW-1:0] c);
      parse_result_t r;
      int            prod;
      r = '0;
      case (stage_q)
        StCmd: begin
          if (is_upper(c)) begin
            cmd_q   = c;
            got_cnt = '0;
            stage_q = StLen;
          end else begin
            stage_q     = StWait;
            r.event_res = EvDrop;
          end
        end
        StLen: begin
          got_cnt = '0;
          if (c == ChDig0) begin
            need_cnt = '0;
            stage_q  = StEnd;
          end else if (c >= ChDig1 && c <= ChDig9) begin
            prod     = UNIT_CHARS * (int'(c) - int'(ChDig0));
            need_cnt = prod[CountW-1:0];
            stage_q  = (need_cnt == '0) ? StEnd : StData;
          end else if (c == ChOpen) begin
            stage_q     = StCmd;
            r.event_res = EvDrop;
          end else begin
            stage_q     = StWait;
            r.event_res = EvDrop;
          end
        end
        StData: begin
          if (is_payload(c)) begin
            r.event_res  = EvData;
            r.data_byte  = c;
            r.data_index = got_cnt;
            got_cnt      = got_cnt + 1'b1;
            // last payload char moves straight on to the closing bracket check
            if (got_cnt >= need_cnt) stage_q = StEnd;
          end else if (c == ChOpen) begin
            stage_q     = StCmd;
            r.event_res = EvDrop;
          end else begin
            stage_q     = StWait;
            r.event_res = EvDrop;
          end
        end
        StEnd: begin
          if (c == ChClose) begin
            r.event_res  = EvDone;
            r.msg_length = need_cnt;
            stage_q      = StWait;
          end else if (c == ChOpen) begin
            stage_q     = StCmd;
            r.event_res = EvDrop;
          end else begin
            stage_q     = StWait;
            r.event_res = EvDrop;
          end
        end
        default: begin
          stage_q = StWait;
          if (c == ChOpen) begin
            got_cnt = '0;
            stage_q = StCmd;
          end
        end
      endcase
      r.command = cmd_q;
      return r;
    endfunction

    function void note_char(logic [CharW-1:0] c);
      pending_events.push_back(parse_char(c));
    endfunction

    function void compare_field(string name, logic [CharW-1:0] want, logic [CharW-1:0] seen);
      if (want !== seen) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, seen);
      end
    endfunction

    function void check_result(parse_result_t seen);
      parse_result_t want;
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with nothing pending, expected none, actual event %0d",
                   $time, seen.event_res);
        return;
      end
      want = pending_events.pop_front();
      compare_field("event_res",  CharW'(want.event_res),  CharW'(seen.event_res));
      compare_field("data_byte",  want.data_byte,          seen.data_byte);
      compare_field("data_index", CharW'(want.data_index), CharW'(seen.data_index));
      compare_field("command",    want.command,            seen.command);
      compare_field("msg_length", CharW'(want.msg_length), CharW'(seen.msg_length));
    endfunction

  endclass

endpackage

// ===== tb/bracket_frame_parser_tb.sv =====
// ----------------------------------------------------------------------------
// bracket_frame_parser_tb
// Self-checking bench: streams directed and random character traffic into the
// parser, predicts every event in the scoreboard and checks results in order,
// with random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module bracket_frame_parser_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import bfp_pkg::*;
  import bfp_tb_pkg::*;

  localparam int CYCLE_LIMIT   = 200_000;
  localparam int PHASE_CHARS   = 384;   // counted frame chars per random phase
  localparam int LONG_HOLD     = 120;   // cycles of output back-pressure
  localparam int DRAIN_CYCLES  = 8;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic [CharW-1:0]  char_in_i   = '0;
  logic              out_ready_i = 1'b0;
  logic              in_ready_o;
  logic              out_valid_o;
  logic [EventW-1:0] event_res_o;
  logic [CharW-1:0]  data_byte_o;
  logic [CountW-1:0] data_index_o;
  logic [CharW-1:0]  command_o;
  logic [CountW-1:0] msg_length_o;

  frame_scoreboard sb = new();

  int send_idle_pct  = 25;
  int recv_idle_pct  = 58;
  bit long_hold_req  = 1'b0;
  bit long_hold_done = 1'b0;
  int cycle_count    = 0;

  bracket_frame_parser dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_in_i    (char_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .event_res_o  (event_res_o),
    .data_byte_o  (data_byte_o),
    .data_index_o (data_index_o),
    .command_o    (command_o),
    .msg_length_o (msg_length_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // watchdog: a stuck handshake or a lost result ends up here
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offer one character and hold it until the transfer happens. Valid is
  // only dropped inside an idle gap, so a back-to-back transfer never sees a
  // low and a high written in the same step.
  task automatic send_char(input logic [CharW-1:0] c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_in_i  <= c;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_char(c);
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_char(s[i]);
  endtask

  function automatic logic [CharW-1:0] pick_payload();
    int k;
    k = $urandom_range(0, 61);
    if (k < 26) return CharW'(ChUpA + k);
    if (k < 52) return CharW'(ChLoA + k - 26);
    return CharW'(ChDig0 + k - 52);
  endfunction

  // One chunk of random traffic: line noise, a clean frame, or a frame cut
  // short by a bad character or a fresh '['. Noise does not count.
  task automatic send_random_chunk(inout int counted);
    logic [CharW-1:0] frame_q[$];
    int               pick;
    int               digit;
    int               cut;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      repeat ($urandom_range(1, 3)) send_char(CharW'($urandom_range(0, 255)));
      return;
    end
    // mostly short payloads, now and then up to the full nine units
    digit = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(4, 9);
    frame_q.push_back(ChOpen);
    frame_q.push_back(CharW'(ChUpA + $urandom_range(0, 25)));
    frame_q.push_back(CharW'(ChDig0 + digit));
    repeat (digit * UNIT_CHARS) frame_q.push_back(pick_payload());
    frame_q.push_back(ChClose);
    if (pick >= 82) begin
      cut = $urandom_range(1, frame_q.size() - 1);
      while (frame_q.size() > cut) void'(frame_q.pop_back());
      frame_q.push_back($urandom_range(0, 1) ? ChOpen : CharW'($urandom_range(0, 255)));
    end
    foreach (frame_q[i]) send_char(frame_q[i]);
    counted += frame_q.size();
  endtask

  task automatic run_random_phase(input int snd_pct, input int rcv_pct);
    int counted;
    counted       = 0;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    while (counted < PHASE_CHARS) send_random_chunk(counted);
  endtask

  // output side: random ready, plus one long hold-off requested by the
  // stimulus and timed here
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req && !long_hold_done) begin
        hold_left      = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    parse_result_t seen;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.event_res  = event_res_o;
      seen.data_byte  = data_byte_o;
      seen.data_index = data_index_o;
      seen.command    = command_o;
      seen.msg_length = msg_length_o;
      sb.check_result(seen);
    end
  end

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero length, a short good frame, bad command ('[' itself),
    // restart from the data, end and length stages, bad data char, bad end
    // char, bad length char; 0x00 and 0xFF ride along as the broken chars
    send_text("[A0]");
    send_text("[Z1a9]");
    send_text("[[");
    send_text("[C1[D1z");
    send_char(8'h00);
    send_text("[E0[F[G0");
    send_char(8'hFF);
    send_text("[H/");

    run_random_phase(25, 58);
    run_random_phase(58, 25);
    // no idling either side; the sink starts its long hold-off right away
    // while frames keep coming, so the pipe backs up into in_ready
    long_hold_req = 1'b1;
    run_random_phase(0, 0);

    in_valid_i <= 1'b0;
    while (sb.pending_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/bfp_pkg.sv
rtl/core/bfp_step.sv
rtl/core/bracket_frame_parser.sv
tb/bfp_tb_pkg.sv
tb/bracket_frame_parser_tb.sv
